FILE: hdl/decimal_fixed_point_parser_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decimal fixed-point parser
// Shared concurrent-assertion wrappers, clocked on aclk, reset on aresetn.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_POINT_PARSER_UNIT_ASSERT_SVH
`define DECIMAL_FIXED_POINT_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication
`define DFPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DFPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dfpp_pkg.sv
// ---------------------------------------------------------------------------
// dfpp_pkg
// Types, character codes and the power-of-ten table for the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dfpp_pkg;

    localparam int ACC_W  = 32;
    localparam int POW_W  = 30;
    localparam int PROD_W = ACC_W + POW_W;
    localparam int SUM_W  = ACC_W + 4;

    // Largest magnitude a parse may reach (a negative full-scale value)
    localparam logic [ACC_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [ACC_W-1:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] NEG_MIN   = 32'h8000_0000;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_TRAIL
    } dfpp_phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_OVERFLOW = 2'd2
    } dfpp_status_t;

    // Request passed from the parse stage to the result stage
    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic              negative;
        logic              syntax_err;
        logic              overflow;
    } dfpp_scaled_t;

    // Ten to the power k, for padding missing fraction digits
    function automatic logic [POW_W-1:0] pow10(input logic [3:0] k);
        logic [POW_W-1:0] p;
        unique case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dfpp_parse.sv
// ---------------------------------------------------------------------------
// dfpp_parse
// Character register, per-character parse state and end-of-string scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module dfpp_parse import dfpp_pkg::*; #(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [3:0]   fraction_digits,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // [7:0] char_code
    output logic              sc_valid,
    input  wire logic         sc_ready,
    output dfpp_scaled_t      sc_data
);

`include "decimal_fixed_point_parser_unit_assert.svh"

    localparam logic [3:0] MAX_FD = 4'(MAX_FRACTION_DIGITS);

    logic               c_valid_reg;
    logic [7:0]         c_code_reg;
    dfpp_phase_t        phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [3:0]         fcount_reg, fcount_next;
    logic               err_reg, err_next;
    logic               ovf_reg, ovf_next;
    logic               sc_valid_reg;
    dfpp_scaled_t       sc_data_reg;

    logic               is_term, is_digit, is_space;
    logic               c_adv, do_shift;
    logic [3:0]         eff_digits, scale_k;
    logic [SUM_W-1:0]   shift_sum;

    // Character classification
    assign is_term  = (c_code_reg == CH_NUL);
    assign is_digit = (c_code_reg >= CH_ZERO) && (c_code_reg <= CH_NINE);
    assign is_space = (c_code_reg == CH_SPACE) ||
                      ((c_code_reg >= CH_TAB) && (c_code_reg <= CH_CR));

    // Clamp the fraction digit count
    assign eff_digits = (fraction_digits > MAX_FD) ? MAX_FD : fraction_digits;

    // Advance unless a terminator is blocked by a full scale stage
    assign c_adv    = c_valid_reg && (!is_term || !sc_valid_reg || sc_ready);
    assign s_tready = !c_valid_reg || c_adv;

    // Times ten plus digit, by shift and add
    assign shift_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                       {{(SUM_W-4){1'b0}}, c_code_reg[3:0]};

    // Zeros still owed at the end of the string
    assign scale_k = (fcount_reg < eff_digits) ? (eff_digits - fcount_reg) : 4'd0;

    // Input character register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (s_tready) begin
            c_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            c_code_reg <= s_tdata;
        end
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            fcount_reg <= '0;
            err_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            fcount_reg <= fcount_next;
            err_reg    <= err_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Next parse state from the current character
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        fcount_next = fcount_reg;
        err_next    = err_reg;
        ovf_next    = ovf_reg;
        do_shift    = 1'b0;
        if (c_adv) begin
            if (is_term) begin
                phase_next  = PH_LEAD;
                acc_next    = '0;
                neg_next    = 1'b0;
                fcount_next = '0;
                err_next    = 1'b0;
                ovf_next    = 1'b0;
            end else if (!err_reg) begin
                priority if (is_digit) begin
                    unique case (phase_reg)
                        PH_LEAD, PH_SIGN, PH_INT: begin
                            do_shift   = 1'b1;
                            phase_next = PH_INT;
                        end
                        PH_FRAC: begin
                            if (fcount_reg < eff_digits) begin
                                do_shift    = 1'b1;
                                fcount_next = fcount_reg + 4'd1;
                            end
                        end
                        default: err_next = 1'b1;
                    endcase
                end else if (c_code_reg == CH_POINT) begin
                    if (phase_reg == PH_LEAD || phase_reg == PH_SIGN ||
                        phase_reg == PH_INT) begin
                        phase_next = PH_FRAC;
                    end else begin
                        err_next = 1'b1;
                    end
                end else if (c_code_reg == CH_MINUS || c_code_reg == CH_PLUS) begin
                    if (phase_reg == PH_LEAD) begin
                        neg_next   = (c_code_reg == CH_MINUS);
                        phase_next = PH_SIGN;
                    end else begin
                        err_next = 1'b1;
                    end
                end else if (is_space) begin
                    if (phase_reg != PH_LEAD) begin
                        phase_next = PH_TRAIL;
                    end
                end else begin
                    err_next = 1'b1;
                end
            end
        end
        // Shift in a digit, freezing the magnitude once it passes the limit
        if (do_shift && !ovf_reg) begin
            if (shift_sum > {4'b0000, MAG_LIMIT}) begin
                ovf_next = 1'b1;
            end else begin
                acc_next = shift_sum[ACC_W-1:0];
            end
        end
    end

    // Scale stage: pad missing fraction digits with one multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (c_adv && is_term) begin
            sc_valid_reg <= 1'b1;
        end else if (sc_ready) begin
            sc_valid_reg <= 1'b0;
        end
        if (c_adv && is_term) begin
            sc_data_reg.product    <= acc_reg * pow10(scale_k);
            sc_data_reg.negative   <= neg_reg;
            sc_data_reg.syntax_err <= err_reg;
            sc_data_reg.overflow   <= ovf_reg;
        end
    end

    assign sc_valid = sc_valid_reg;
    assign sc_data  = sc_data_reg;

    `DFPP_ASSERT_NEXT(a_term_clears, c_adv && is_term,
        phase_reg == PH_LEAD && acc_reg == '0 && !err_reg && !ovf_reg,
        "parse state not cleared after end of string")
    `DFPP_ASSERT_NEXT(a_term_scales, c_adv && is_term, sc_valid_reg,
        "end of string did not produce a scale request")
    `DFPP_ASSERT_NEXT(a_err_sticky, err_reg && !(c_adv && is_term), err_reg,
        "syntax error dropped before end of string")

endmodule

`default_nettype wire

FILE: hdl/dfpp_result.sv
// ---------------------------------------------------------------------------
// dfpp_result
// Final range check, saturation, sign and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dfpp_result import dfpp_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         sc_valid,
    output logic              sc_ready,
    input  wire dfpp_scaled_t sc_data,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata     // [31:0] scaled_value, [33:32] status
);

`include "decimal_fixed_point_parser_unit_assert.svh"

    logic               m_valid_reg;
    logic [39:0]        m_data_reg, m_data_next;
    logic               mag_over, pos_over, ovf_final;
    logic [ACC_W-1:0]   value;
    dfpp_status_t       status;

    // Range checks on the scaled magnitude
    assign mag_over  = sc_data.product > {{(PROD_W-ACC_W){1'b0}}, MAG_LIMIT};
    assign pos_over  = sc_data.product > {{(PROD_W-ACC_W){1'b0}}, POS_MAX};
    assign ovf_final = sc_data.overflow || mag_over || (!sc_data.negative && pos_over);

    // Pick value and status, syntax error first
    always_comb begin
        priority if (sc_data.syntax_err) begin
            value  = '0;
            status = ST_SYNTAX;
        end else if (ovf_final) begin
            value  = sc_data.negative ? NEG_MIN : POS_MAX;
            status = ST_OVERFLOW;
        end else begin
            value  = sc_data.negative ? (ACC_W'(0) - sc_data.product[ACC_W-1:0])
                                      : sc_data.product[ACC_W-1:0];
            status = ST_OK;
        end
        m_data_next = {6'b000000, status, value};
    end

    assign sc_ready = !m_valid_reg || m_tready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sc_ready) begin
            m_valid_reg <= sc_valid;
        end
        if (sc_ready && sc_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DFPP_ASSERT_NOW(a_ovf_saturated,
        m_valid_reg && m_data_reg[33:32] == ST_OVERFLOW,
        m_data_reg[31:0] == POS_MAX || m_data_reg[31:0] == NEG_MIN,
        "overflow result not saturated")
    `DFPP_ASSERT_NOW(a_syntax_zero,
        m_valid_reg && m_data_reg[33:32] == ST_SYNTAX, m_data_reg[31:0] == '0,
        "syntax error result not zero")
    `DFPP_ASSERT_NEXT(a_syntax_status,
        sc_valid && sc_ready && sc_data.syntax_err,
        m_valid_reg && m_data_reg[33:32] == ST_SYNTAX,
        "syntax error not reported")

endmodule

`default_nettype wire

FILE: hdl/decimal_fixed_point_parser_unit.sv
// Path: a terminating zero character loads the character register at the accepting
//   edge, then the scale multiply register, then the output register, which drives
//   its result on m_tvalid.
// Throughput: one character per cycle; characters that end no string keep flowing
//   while a finished result waits on m_tready. A terminator waits for the scale stage.
// Reset: synchronous, active low on aresetn; clears the parse state, pipeline valids
//   and fraction_digits (to 0). No clearing pass.
// ---------------------------------------------------------------------------
// decimal_fixed_point_parser_unit
// ASCII decimal string to 32-bit signed fixed point, one character per request.
// ---------------------------------------------------------------------------
`default_nettype none

module decimal_fixed_point_parser_unit import dfpp_pkg::*; #(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_wdata,  // [3:0] fraction_digits
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // [7:0] char_code
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata     // [31:0] scaled_value, [33:32] status
);

    logic [3:0]     fd_reg;
    logic           sc_valid, sc_ready;
    dfpp_scaled_t   sc_data;

    // Fraction digits register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg <= '0;
        end else if (cfg_we) begin
            fd_reg <= cfg_wdata;
        end
    end

    dfpp_parse #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fraction_digits (fd_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .sc_valid        (sc_valid),
        .sc_ready        (sc_ready),
        .sc_data         (sc_data)
    );

    dfpp_result u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sc_valid (sc_valid),
        .sc_ready (sc_ready),
        .sc_data  (sc_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb: decimal fixed-point parser testbench
// Streams ASCII strings into the parser one character per request and checks
// every scaled value and status against a cycle-free predictor of the parse.
// Covers blank, signed, truncated, padded, malformed and overflowing numbers
// across several fraction-digit settings. Both sides idle at random, and the
// result side holds off once for long enough to back up the input.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import dfpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAC      = 9;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PRINT_LIMIT   = 20;
    localparam int RANDOM_CHARS  = 1950;

    typedef struct {
        logic [31:0]  value;
        dfpp_status_t status;
    } parse_result_t;

    // Predicts parser results and checks them in arrival order
    class parse_scoreboard;
        logic [3:0]    frac_digits;
        dfpp_phase_t   phase;
        logic [31:0]   mag;
        bit            neg;
        bit            err;
        bit            ovf;
        int            frac_seen;
        parse_result_t expected_q[$];
        int            mismatches;
        int            chars_seen;
        int            results_seen;
        int            status_count[3];

        function new();
            frac_digits = '0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase     = PH_LEAD;
            mag       = '0;
            neg       = 1'b0;
            err       = 1'b0;
            ovf       = 1'b0;
            frac_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Multiply by ten and add, flagging once the magnitude passes 2^31
        function void shift_digit(int unsigned d);
            logic [63:0] t;
            if (ovf)
                return;
            t = {32'd0, mag} * 64'd10 + 64'(d);
            if (t > {32'd0, MAG_LIMIT})
                ovf = 1'b1;
            else
                mag = t[31:0];
        endfunction

        function void note_char(logic [7:0] c);
            int            eff;
            parse_result_t r;
            eff = (frac_digits > MAX_FRAC) ? MAX_FRAC : int'(frac_digits);
            chars_seen++;

            // Terminator: pad the fraction, resolve status, restart the parse
            if (c == CH_NUL) begin
                while (frac_seen < eff) begin
                    shift_digit(0);
                    frac_seen++;
                end
                if (!neg && mag > POS_MAX)
                    ovf = 1'b1;
                if (err) begin
                    r.value  = '0;
                    r.status = ST_SYNTAX;
                end else if (ovf) begin
                    r.value  = neg ? NEG_MIN : POS_MAX;
                    r.status = ST_OVERFLOW;
                end else begin
                    r.value  = neg ? -mag : mag;
                    r.status = ST_OK;
                end
                expected_q.push_back(r);
                clear_parse();
                return;
            end

            if (err)
                return;

            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (phase == PH_LEAD || phase == PH_SIGN || phase == PH_INT) begin
                    shift_digit(c - CH_ZERO);
                    phase = PH_INT;
                end else if (phase == PH_FRAC) begin
                    if (frac_seen < eff) begin
                        shift_digit(c - CH_ZERO);
                        frac_seen++;
                    end
                end else begin
                    err = 1'b1;
                end
            end else if (c == CH_POINT) begin
                if (phase == PH_LEAD || phase == PH_SIGN || phase == PH_INT)
                    phase = PH_FRAC;
                else
                    err = 1'b1;
            end else if (c == CH_MINUS || c == CH_PLUS) begin
                if (phase == PH_LEAD) begin
                    neg   = (c == CH_MINUS);
                    phase = PH_SIGN;
                end else begin
                    err = 1'b1;
                end
            end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (phase != PH_LEAD)
                    phase = PH_TRAIL;
            end else begin
                err = 1'b1;
            end
        endfunction

        task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] MISMATCH result %0d %s: expected 0x%08h got 0x%08h",
                         $realtime, results_seen, what, exp_v, got_v);
        endtask

        task check_result(logic [39:0] word);
            parse_result_t r;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", '0, word[31:0]);
                return;
            end
            r = expected_q.pop_front();
            if (r.status <= ST_OVERFLOW)
                status_count[r.status]++;
            if (word[31:0] !== r.value)
                report_mismatch("scaled_value", r.value, word[31:0]);
            if (word[33:32] !== r.status)
                report_mismatch("status", 32'(r.status), 32'(word[33:32]));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    parse_scoreboard sb;
    bit              no_idle;
    bit              sink_hold;
    int              rx_gap;
    int              chars_sent;

    decimal_fixed_point_parser_unit #(
        .MAX_FRACTION_DIGITS(MAX_FRAC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // Append v in decimal, zero-padded to at least width digits
    function automatic void push_number(ref logic [7:0] q[$], input longint unsigned v,
                                        input int width);
        logic [7:0] digits[$];
        int         n;
        n = 0;
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
            n++;
        end while (v != 0 || n < width);
        q = {q, digits};
    endfunction

    // Body of a well-formed number: blanks, sign, digits, point, fraction, blanks
    function automatic void build_number(ref logic [7:0] q[$]);
        int n;
        n = $urandom_range(0, 2);
        repeat (n) q.push_back(pick_space());
        case ($urandom_range(0, 2))
            1: q.push_back(CH_PLUS);
            2: q.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
        repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
            q.push_back(CH_POINT);
            n = $urandom_range(0, 11);
            repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        n = $urandom_range(0, 2);
        repeat (n) q.push_back(pick_space());
    endfunction

    // One random string, always closed by a terminator
    function automatic void build_string(ref logic [7:0] q[$], input int eff);
        int              kind;
        int              pos;
        longint unsigned scale;
        longint unsigned m;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            build_number(q);
        end else if (kind < 70) begin
            // Magnitude right around the signed 32-bit limit at this scale
            scale = 1;
            repeat (eff) scale = scale * 10;
            m = 64'd2147483640 + $urandom_range(0, 16);
            if ($urandom_range(0, 1))
                q.push_back(CH_MINUS);
            push_number(q, m / scale, 1);
            if (eff > 0) begin
                q.push_back(CH_POINT);
                push_number(q, m % scale, eff);
                if ($urandom_range(0, 2) == 0)
                    q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end else if (kind < 85) begin
            // Well-formed number with one character replaced or added
            build_number(q);
            pos = $urandom_range(0, q.size());
            case ($urandom_range(0, 5))
                0: q.insert(pos, CH_POINT);
                1: q.insert(pos, CH_MINUS);
                2: q.insert(pos, CH_PLUS);
                3: q.insert(pos, pick_space());
                4: q.insert(pos, CH_ZERO + 8'($urandom_range(0, 9)));
                default: begin
                    if (pos < q.size())
                        q[pos] = 8'($urandom_range(1, 255));
                    else
                        q.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end else begin
            kind = $urandom_range(1, 8);
            repeat (kind) q.push_back(8'($urandom_range(1, 255)));
        end
        q.push_back(CH_NUL);
    endfunction

    // Offer one character; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        sb.note_char(c);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_string(input logic [7:0] q[$]);
        foreach (q[i]) send_char(q[i]);
    endtask

    // Wait for every outstanding result, let the pipeline settle, then write
    task automatic write_frac_digits(input logic [3:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we         <= 1'b0;
        sb.frac_digits  = v;
    endtask

    // Check every accepted result and draw the next hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
            rx_gap = draw_gap();
        end
    end

    // Drive ready: low during a hold-off or the long hold, high otherwise
    always @(negedge aclk) begin
        if (!aresetn || sink_hold || rx_gap > 0) begin
            m_tready <= 1'b0;
            if (rx_gap > 0)
                rx_gap = rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Run limit
    initial begin
        #8ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        string      directed[] = '{"", " ", "-", ".5", "1.2.", "1 2", "2-", "- 3",
                                   "\377"};
        logic [3:0] settings[] = '{4'd9, 4'd0, 4'd15, 4'd4, 4'd1, 4'd10, 4'd6};
        logic [7:0] q[$];
        int         budget;
        int         eff;

        sb         = new();
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        no_idle    = 1'b0;
        sink_hold  = 1'b0;
        rx_gap     = 0;
        chars_sent = 0;

        // Hold reset, then release it at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed strings: blank, lone sign, leading point, misplaced and invalid characters
        write_frac_digits(4'd2);
        foreach (directed[i]) begin
            q.delete();
            for (int k = 0; k < directed[i].len(); k++)
                q.push_back(directed[i][k]);
            q.push_back(CH_NUL);
            send_string(q);
        end

        // Random strings under each fraction-digit setting
        budget = RANDOM_CHARS / settings.size();
        foreach (settings[p]) begin
            write_frac_digits(settings[p]);
            eff     = (settings[p] > MAX_FRAC) ? MAX_FRAC : int'(settings[p]);
            no_idle = (p == 3);
            if (p == 1) begin
                fork
                    begin
                        @(posedge aclk);
                        sink_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            chars_sent = 0;
            while (chars_sent < budget) begin
                q.delete();
                build_string(q, eff);
                send_string(q);
            end
        end

        // Drain
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d characters and %0d strings over %0d register settings",
                 sb.chars_seen, sb.results_seen, settings.size() + 1);
        $display("statuses: %0d ok, %0d syntax, %0d overflow; %0d mismatches",
                 sb.status_count[ST_OK], sb.status_count[ST_SYNTAX],
                 sb.status_count[ST_OVERFLOW], sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/dfpp_pkg.sv
hdl/dfpp_parse.sv
hdl/dfpp_result.sv
hdl/decimal_fixed_point_parser_unit.sv
dv/tb.sv
